// ===== rtl/bscu_pkg.sv =====
// ----------------------------------------------------------------------------
// bscu_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bscu_pkg;

  // width of the internal temperature (t scaled by 2^48)
  localparam int TW = 61;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CALIB    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_B = 2'd2;

  localparam logic [23:0] PRESS_MAX = 24'hFFFFFF;
  localparam logic signed [17:0] TEMP_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] TEMP_MIN = 18'sh20000;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } item_t;

  typedef struct packed {
    logic signed [17:0] temperature_q10;
    logic [23:0]        pressure_q6;
    logic               clipped;
  } result_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic [15:0]        t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic [15:0]        p5;
    logic [15:0]        p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } calib_t;

  // temperature and horner coefficients, all over powers of two
  typedef struct packed {
    logic                valid;
    logic signed [60:0]  t;
    logic signed [63:0]  a3;
    logic signed [127:0] a2;
    logic signed [191:0] a1;
    logic signed [255:0] a0;
  } front_t;

  typedef struct packed {
    logic signed [17:0] q10;
    logic               clip;
  } temp_res_t;

endpackage

`default_nettype wire

// ===== rtl/bscu_cfg.sv =====
// ----------------------------------------------------------------------------
// bscu_cfg
// Calibration register file, unpacked into individual coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module bscu_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [bscu_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [63:0]                        wr_data,
  output bscu_pkg::calib_t                        calib
);

  logic [39:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        bscu_pkg::CFG_TEMP_CALIB:    temp_calib    <= wr_data[39:0];
        bscu_pkg::CFG_PRESS_CALIB_A: press_calib_a <= wr_data;
        bscu_pkg::CFG_PRESS_CALIB_B: press_calib_b <= wr_data;
        default: ;
      endcase
    end
  end

  assign calib.t1  = temp_calib[15:0];
  assign calib.t2  = temp_calib[31:16];
  assign calib.t3  = temp_calib[39:32];
  assign calib.p1  = press_calib_a[15:0];
  assign calib.p2  = press_calib_a[31:16];
  assign calib.p3  = press_calib_a[39:32];
  assign calib.p4  = press_calib_a[47:40];
  assign calib.p5  = press_calib_a[63:48];
  assign calib.p6  = press_calib_b[15:0];
  assign calib.p7  = press_calib_b[23:16];
  assign calib.p8  = press_calib_b[31:24];
  assign calib.p9  = press_calib_b[47:32];
  assign calib.p10 = press_calib_b[55:48];
  assign calib.p11 = press_calib_b[63:56];

endmodule

`default_nettype wire

// ===== rtl/bscu_front.sv =====
// ----------------------------------------------------------------------------
// bscu_front
// Three stages: temperature polynomial and pressure horner coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module bscu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  bscu_pkg::item_t        item,
  input  bscu_pkg::calib_t       calib,
  output bscu_pkg::front_t       front
);

  logic signed [7:0]  t3c, p3c, p4c, p7c, p8c, p10c, p11c;
  logic signed [15:0] p1c, p2c, p9c;

  assign t3c  = calib.t3;
  assign p1c  = calib.p1;
  assign p2c  = calib.p2;
  assign p3c  = calib.p3;
  assign p4c  = calib.p4;
  assign p7c  = calib.p7;
  assign p8c  = calib.p8;
  assign p9c  = calib.p9;
  assign p10c = calib.p10;
  assign p11c = calib.p11;

  // stage 1
  logic               v1;
  logic signed [25:0] d1;
  logic [23:0]        r1;
  logic [47:0]        r2_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    d1   <= $signed({2'b00, item.raw_temperature}) - $signed({2'b00, calib.t1, 8'h00});
    r1   <= item.raw_pressure;
    r2_1 <= item.raw_pressure * item.raw_pressure;
  end

  // stage 2
  logic               v2;
  logic signed [42:0] dt2_2;
  logic signed [51:0] dd_2;
  logic [71:0]        r3_2;
  logic signed [32:0] c4r_2, c3r_2;
  logic signed [41:0] c2r_2, c1r_2;
  logic signed [56:0] c10r2_2;
  logic signed [64:0] c9r2_2;
  logic signed [24:0] r1s;
  logic signed [48:0] r2s;

  assign r1s = $signed({1'b0, r1});
  assign r2s = $signed({1'b0, r2_1});

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    dt2_2   <= d1 * $signed({1'b0, calib.t2});
    dd_2    <= d1 * d1;
    r3_2    <= r2_1 * 72'(r1);
    c4r_2   <= p4c * r1s;
    c3r_2   <= p3c * r1s;
    c2r_2   <= (17'(p2c) - 17'sd16384) * r1s;
    c1r_2   <= (17'(p1c) - 17'sd16384) * r1s;
    c10r2_2 <= p10c * r2s;
    c9r2_2  <= p9c * r2s;
  end

  // stage 3
  logic signed [80:0] c11r3;
  assign c11r3 = p11c * $signed({1'b0, r3_2});

  always_ff @(posedge clk) begin
    if (rst) front.valid <= 1'b0;
    else     front.valid <= v2;
    front.t  <= (61'(dt2_2) <<< 18) + dd_2 * t3c;
    front.a3 <= (64'(p8c) <<< 50) + (64'(c4r_2) <<< 28);
    front.a2 <= (128'(p7c) <<< 105) + (128'(c3r_2) <<< 81);
    front.a1 <= (192'($signed({1'b0, calib.p6})) <<< 155) + (192'(c2r_2) <<< 132)
              + (192'(c10r2_2) <<< 113);
    front.a0 <= (256'($signed({1'b0, calib.p5})) <<< 212) + (256'(c1r_2) <<< 189)
              + (256'(c9r2_2) <<< 161) + (256'(c11r3) <<< 144);
  end

endmodule

`default_nettype wire

// ===== rtl/bscu_horner.sv =====
// ----------------------------------------------------------------------------
// bscu_horner
// One horner step, acc * t + coef, in three stages: 33x33 limb products,
// row sums and the final add, with side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module bscu_horner #(
  parameter int A_W = 64,
  parameter int O_W = 128,
  parameter int S_W = 19
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic signed [A_W-1:0]              acc_in,
  input  wire logic signed [bscu_pkg::TW-1:0]     t_in,
  input  wire logic signed [O_W-1:0]              coef,
  input  wire logic [S_W-1:0]                     side_in,
  output logic                                    out_valid,
  output logic signed [O_W-1:0]                   acc_out,
  output logic signed [bscu_pkg::TW-1:0]          t_out,
  output logic [S_W-1:0]                          side_out
);

  localparam int NA  = (A_W + 31) / 32;
  localparam int NT  = (bscu_pkg::TW + 31) / 32;
  localparam int AXW = NA * 32;
  localparam int TXW = NT * 32;

  logic signed [AXW-1:0] a_ext;
  logic signed [TXW-1:0] t_ext;
  logic signed [32:0]    a_limb [NA];
  logic signed [32:0]    t_limb [NT];

  assign a_ext = AXW'(acc_in);
  assign t_ext = TXW'(t_in);

  // low limbs are unsigned, the top limb carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_a_limb
    if (i == NA - 1) begin : g_top
      assign a_limb[i] = {a_ext[32*i+31], a_ext[32*i +: 32]};
    end else begin : g_low
      assign a_limb[i] = {1'b0, a_ext[32*i +: 32]};
    end
  end

  for (genvar j = 0; j < NT; j++) begin : g_t_limb
    if (j == NT - 1) begin : g_top
      assign t_limb[j] = {t_ext[32*j+31], t_ext[32*j +: 32]};
    end else begin : g_low
      assign t_limb[j] = {1'b0, t_ext[32*j +: 32]};
    end
  end

  // stage 1: limb products
  logic                           v_s1;
  logic signed [65:0]             pp_s1 [NA][NT];
  logic signed [O_W-1:0]          coef_s1;
  logic signed [bscu_pkg::TW-1:0] t_s1;
  logic [S_W-1:0]                 side_s1;

  always_ff @(posedge clk) begin
    if (rst) v_s1 <= 1'b0;
    else     v_s1 <= in_valid;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NT; j++) begin
        pp_s1[i][j] <= a_limb[i] * t_limb[j];
      end
    end
    coef_s1 <= coef;
    t_s1    <= t_in;
    side_s1 <= side_in;
  end

  // stage 2: one row per t limb
  logic signed [O_W-1:0] row_sum [NT];

  always_comb begin
    for (int j = 0; j < NT; j++) begin
      row_sum[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_sum[j] = row_sum[j] + (O_W'(pp_s1[i][j]) <<< (32 * i));
      end
    end
  end

  logic                           v_s2;
  logic signed [O_W-1:0]          row_s2 [NT];
  logic signed [O_W-1:0]          coef_s2;
  logic signed [bscu_pkg::TW-1:0] t_s2;
  logic [S_W-1:0]                 side_s2;

  always_ff @(posedge clk) begin
    if (rst) v_s2 <= 1'b0;
    else     v_s2 <= v_s1;
    for (int j = 0; j < NT; j++) begin
      row_s2[j] <= row_sum[j];
    end
    coef_s2 <= coef_s1;
    t_s2    <= t_s1;
    side_s2 <= side_s1;
  end

  // stage 3: rows plus coefficient
  logic signed [O_W-1:0] total;

  always_comb begin
    total = coef_s2;
    for (int j = 0; j < NT; j++) begin
      total = total + (row_s2[j] <<< (32 * j));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v_s2;
    acc_out  <= total;
    t_out    <= t_s2;
    side_out <= side_s2;
  end

endmodule

`default_nettype wire

// ===== rtl/baro_sensor_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Polynomial temperature and pressure compensation of raw sensor readings.
// ----------------------------------------------------------------------------
// throughput: one item per cycle, busy is always low; no back-pressure
// pipeline: three front stages, three horner steps of three stages each, output stage
// reset (rst, synchronous): clears calibration registers and all stage valids
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // item channel
  input  wire logic                             start,
  output logic                                  busy,
  input  bscu_pkg::item_t                       item,
  // result channel
  output logic                                  result_valid,
  output bscu_pkg::result_t                     result,
  // calibration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bscu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [63:0]                      cfg_data
);

  localparam int S1_W = 192 + 256 + 19;
  localparam int S2_W = 256 + 19;
  localparam int S3_W = 19;

  // every stage advances every cycle, so nothing ever holds off a start
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  bscu_pkg::calib_t calib;

  bscu_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .calib    (calib)
  );

  // temperature polynomial and coefficients of P(t) = a0 + t*(a1 + t*(a2 + t*a3))
  bscu_pkg::front_t front;

  bscu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .item     (item),
    .calib    (calib),
    .front    (front)
  );

  // temperature result: floor(t * 1024) is t48 shifted down by 38
  bscu_pkg::temp_res_t temp_res;
  logic signed [22:0]  tq;
  logic                t_ovf;

  assign tq    = front.t[60:38];
  // out of 18-bit range unless the six top bits of tq are all sign copies
  assign t_ovf = !((&tq[22:17]) || !(|tq[22:17]));

  always_comb begin
    temp_res.clip = t_ovf;
    if (!t_ovf)         temp_res.q10 = tq[17:0];
    else if (tq[22])    temp_res.q10 = bscu_pkg::TEMP_MIN;
    else                temp_res.q10 = bscu_pkg::TEMP_MAX;
  end

  // horner step 1: a3 * t + a2
  logic                         h1_valid;
  logic signed [127:0]          h1_acc;
  logic signed [bscu_pkg::TW-1:0] h1_t;
  logic [S1_W-1:0]              h1_side;

  bscu_horner #(.A_W(64), .O_W(128), .S_W(S1_W)) u_h1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front.valid),
    .acc_in    (front.a3),
    .t_in      (front.t),
    .coef      (front.a2),
    .side_in   ({front.a1, front.a0, temp_res}),
    .out_valid (h1_valid),
    .acc_out   (h1_acc),
    .t_out     (h1_t),
    .side_out  (h1_side)
  );

  // horner step 2: . * t + a1
  logic                         h2_valid;
  logic signed [191:0]          h2_acc;
  logic signed [bscu_pkg::TW-1:0] h2_t;
  logic [S2_W-1:0]              h2_side;

  bscu_horner #(.A_W(128), .O_W(192), .S_W(S2_W)) u_h2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h1_valid),
    .acc_in    (h1_acc),
    .t_in      (h1_t),
    .coef      ($signed(h1_side[S1_W-1:S2_W])),
    .side_in   (h1_side[S2_W-1:0]),
    .out_valid (h2_valid),
    .acc_out   (h2_acc),
    .t_out     (h2_t),
    .side_out  (h2_side)
  );

  // horner step 3: . * t + a0, the pressure times 2^209
  logic                         h3_valid;
  logic signed [255:0]          h3_acc;
  logic signed [bscu_pkg::TW-1:0] h3_t;
  logic [S3_W-1:0]              h3_side;

  bscu_horner #(.A_W(192), .O_W(256), .S_W(S3_W)) u_h3 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h2_valid),
    .acc_in    (h2_acc),
    .t_in      (h2_t),
    .coef      ($signed(h2_side[S2_W-1:S3_W])),
    .side_in   (h2_side[S3_W-1:0]),
    .out_valid (h3_valid),
    .acc_out   (h3_acc),
    .t_out     (h3_t),
    .side_out  (h3_side)
  );

  // output stage: floor(P * 64) from the top bits, saturate at both ends
  bscu_pkg::temp_res_t tr3;
  bscu_pkg::result_t   res_next;
  logic [52:0]         pq;
  logic                unused_t;

  assign tr3      = h3_side;
  assign pq       = h3_acc[255:203];
  assign unused_t = ^h3_t;

  always_comb begin
    res_next.temperature_q10 = tr3.q10;
    if (pq[52]) begin
      res_next.pressure_q6 = '0;
      res_next.clipped     = 1'b1;
    end else if (|pq[51:24]) begin
      res_next.pressure_q6 = bscu_pkg::PRESS_MAX;
      res_next.clipped     = 1'b1;
    end else begin
      res_next.pressure_q6 = pq[23:0];
      res_next.clipped     = tr3.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= h3_valid && (unused_t || !unused_t);
    result <= res_next;
  end

  // each transfer in yields exactly one result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##13 result_valid)
    else $error("result missing thirteen cycles after start");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, 13))
    else $error("result without matching start");

  // a result with both fields off their limits never reports clipping
  a_clip: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pressure_q6 != 24'h000000
     && result.pressure_q6 != bscu_pkg::PRESS_MAX
     && result.temperature_q10 != bscu_pkg::TEMP_MAX
     && result.temperature_q10 != bscu_pkg::TEMP_MIN) |-> !result.clipped)
    else $error("clipped set on unsaturated result");

endmodule

`default_nettype wire

// ===== tb/baro_sensor_compensation_checker.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation_checker
// Watches the calibration, item and result channels of the compensation unit.
// Keeps its own copy of the calibration and works out each expected result
// with exact wide integer math. Results are compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module baro_sensor_compensation_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  bscu_pkg::item_t  item,
  input  wire logic        result_valid,
  input  bscu_pkg::result_t result,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [bscu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               mismatches,
  output int               pending,
  output int               checked,
  output int               clipped_seen
);

  localparam int WW  = 384;
  localparam int DEN = 209;

  logic [39:0] temp_cal;
  logic [63:0] press_a;
  logic [63:0] press_b;
  bscu_pkg::result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [WW-1:0] poly_term(longint coef,
      logic signed [WW-1:0] tq, int tp, logic signed [WW-1:0] rw, int rp, int div);
    logic signed [WW-1:0] p;
    p = coef;
    for (int k = 0; k < tp; k++) p = p * tq;
    for (int k = 0; k < rp; k++) p = p * rw;
    return p <<< (DEN - tp * 48 - div);
  endfunction

  function automatic bscu_pkg::result_t compensate(bscu_pkg::item_t it);
    longint t1, t2, t3, d, t48, tq10;
    logic signed [WW-1:0] tq, rw, acc, q;
    logic clip;
    bscu_pkg::result_t res;
    clip = 1'b0;
    t1 = temp_cal[15:0];
    t2 = temp_cal[31:16];
    t3 = longint'($signed(temp_cal[39:32]));
    d = longint'(it.raw_temperature) - 256 * t1;
    t48 = d * t2 * 262144 + d * d * t3;
    // floor to 1/1024 degree
    tq10 = t48 >>> 38;
    if (tq10 > 131071) begin
      tq10 = 131071;
      clip = 1'b1;
    end
    if (tq10 < -131072) begin
      tq10 = -131072;
      clip = 1'b1;
    end
    tq = t48;
    rw = {360'd0, it.raw_pressure};
    acc = '0;
    acc += poly_term(longint'(press_a[63:48]), tq, 0, rw, 0, -3);
    acc += poly_term(longint'(press_b[15:0]), tq, 1, rw, 0, 6);
    acc += poly_term(longint'($signed(press_b[23:16])), tq, 2, rw, 0, 8);
    acc += poly_term(longint'($signed(press_b[31:24])), tq, 3, rw, 0, 15);
    acc += poly_term(longint'($signed(press_a[15:0])) - 16384, tq, 0, rw, 1, 20);
    acc += poly_term(longint'($signed(press_a[31:16])) - 16384, tq, 1, rw, 1, 29);
    acc += poly_term(longint'($signed(press_a[39:32])), tq, 2, rw, 1, 32);
    acc += poly_term(longint'($signed(press_a[47:40])), tq, 3, rw, 1, 37);
    acc += poly_term(longint'($signed(press_b[47:32])), tq, 0, rw, 2, 48);
    acc += poly_term(longint'($signed(press_b[55:48])), tq, 1, rw, 2, 48);
    acc += poly_term(longint'($signed(press_b[63:56])), tq, 0, rw, 3, 65);
    q = acc >>> (DEN - 6);
    if (q < 0) begin
      res.pressure_q6 = '0;
      clip = 1'b1;
    end else if (q > 16777215) begin
      res.pressure_q6 = bscu_pkg::PRESS_MAX;
      clip = 1'b1;
    end else begin
      res.pressure_q6 = q[23:0];
    end
    res.temperature_q10 = tq10[17:0];
    res.clipped = clip;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 30)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    bscu_pkg::result_t want;
    if (rst) begin
      temp_cal <= '0;
      press_a <= '0;
      press_b <= '0;
      expected_q.delete();
      mismatches <= 0;
      checked <= 0;
      clipped_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bscu_pkg::CFG_TEMP_CALIB:    temp_cal <= cfg_data[39:0];
          bscu_pkg::CFG_PRESS_CALIB_A: press_a <= cfg_data;
          bscu_pkg::CFG_PRESS_CALIB_B: press_b <= cfg_data;
          default: ;
        endcase
      end
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", result, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.temperature_q10 !== want.temperature_q10)
            report("temperature_q10", result.temperature_q10, want.temperature_q10);
          if (result.pressure_q6 !== want.pressure_q6)
            report("pressure_q6", result.pressure_q6, want.pressure_q6);
          if (result.clipped !== want.clipped)
            report("clipped", result.clipped, want.clipped);
          checked <= checked + 1;
          if (want.clipped) clipped_seen <= clipped_seen + 1;
        end
      end
      if (start && !busy) expected_q.push_back(compensate(item));
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_baro_sensor_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation_unit
// Stimulus and verdict for the barometric compensation unit. Runs calibration
// sets (zero, all ones, signed extremes, realistic, random), directed raw
// extremes and random readings; the checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_baro_sensor_compensation_unit;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS_PER_SET = 258;
  // index past the last calibration register
  localparam logic [bscu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  bscu_pkg::item_t item;
  logic result_valid;
  bscu_pkg::result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [bscu_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  int mismatches, pending, checked, clipped_seen;
  int idle_cycles;
  int items_sent;
  int cal_sets;
  logic no_gaps;

  baro_sensor_compensation_unit i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  baro_sensor_compensation_checker i_checker (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending),
    .checked(checked), .clipped_seen(clipped_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: any stretch with no transfer on any channel is bounded
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one item transfer; start stays high across back-to-back items
  task automatic send_reading(input logic [23:0] rp, input logic [23:0] rt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item.raw_pressure <= rp;
    item.raw_temperature <= rt;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // let the pipeline drain so calibration changes only while idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cal(input logic [bscu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    int gap;
    gap = $urandom_range(0, 12);
    repeat (gap) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cal_set(input logic [63:0] tc, input logic [63:0] pa,
                              input logic [63:0] pb);
    drain();
    write_cal(bscu_pkg::CFG_TEMP_CALIB, tc);
    write_cal(bscu_pkg::CFG_PRESS_CALIB_A, pa);
    write_cal(bscu_pkg::CFG_PRESS_CALIB_B, pb);
    // writes to the unused index must leave the calibration alone
    write_cal(CFG_UNUSED_INDEX, {$urandom, $urandom});
    cal_sets++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // half the readings near the calibrated zero point, the rest over the full range or at its ends
  task automatic random_readings(input int n, input logic [15:0] t1);
    logic [23:0] rt, rp;
    int center;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      center = int'(t1) * 256;
      case ($urandom_range(0, 3))
        0, 1: rt = 24'(center + $urandom_range(0, 262143) - 131072);
        2:    rt = 24'($urandom);
        default: rt = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      endcase
      rp = ($urandom_range(0, 7) == 0) ? {24{$urandom_range(0, 1) == 1}} : 24'($urandom);
      send_reading(rp, rt);
      // one hold-off until the pipeline is empty, in the middle of a set
      if (i == n / 2 && cal_sets == 3) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [63:0] tc, pa, pb;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    cal_sets = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // realistic set: T1 27540, T2 19200, T3 -7 and modest pressure terms
    tc = {24'd0, 8'hF9, 16'd19200, 16'd27540};
    pa = {16'd24000, 8'hF6, 8'h05, 16'hF000, 16'hF000};
    pb = {8'h05, 8'hF0, 16'd8000, 8'h0C, 8'hF8, 16'd30000};
    load_cal_set(tc, pa, pb);

    // directed: raw extremes, alternating bits, temperature saturating at the top
    send_reading(24'h000000, 24'h000000);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h000000, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'h000000);
    send_reading(24'hAAAAAA, 24'h555555);
    send_reading(24'h555555, 24'hAAAAAA);
    send_reading(24'h6B0000, 24'd27540 * 256);
    send_reading(24'h6B0000, 24'd27540 * 256 + 24'd500000);
    send_reading(24'h6B0000, 24'd27540 * 256 - 24'd500000);
    send_reading(24'h800000, 24'h800000);
    send_reading(24'h000001, 24'h7FFFFF);
    send_reading(24'h7FFFFF, 24'h000001);
    send_reading(24'h400000, 24'd27540 * 256 + 24'd1000);
    random_readings(ITEMS_PER_SET, 16'd27540);

    // zero calibration, temperature equals nothing, pressure heavily negative
    load_cal_set(64'd0, 64'd0, 64'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h000000, 24'h000000);
    random_readings(ITEMS_PER_SET / 2, 16'd0);

    // all ones in every field
    load_cal_set('1, '1, '1);
    send_reading(24'hFFFFFF, 24'h000000);
    random_readings(ITEMS_PER_SET, 16'hFFFF);

    // largest positive signed fields, drives pressure to its upper limit
    load_cal_set({24'd0, 8'h7F, 16'hFFFF, 16'h0000},
                 {16'hFFFF, 8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
                 {8'h7F, 8'h7F, 16'h7FFF, 8'h7F, 8'h7F, 16'hFFFF});
    random_readings(ITEMS_PER_SET / 2, 16'h0000);

    // most negative signed fields
    load_cal_set({24'd0, 8'h80, 16'h0001, 16'h8000},
                 {16'h0000, 8'h80, 8'h80, 16'h8000, 16'h8000},
                 {8'h80, 8'h80, 16'h8000, 8'h80, 8'h80, 16'h0000});
    random_readings(ITEMS_PER_SET / 2, 16'h8000);

    for (int s = 0; s < 4; s++) begin
      tc = rand64();
      pa = rand64();
      pb = rand64();
      load_cal_set(tc, pa, pb);
      random_readings(ITEMS_PER_SET, tc[15:0]);
    end

    drain();
    $display("covered %0d readings over %0d calibration sets", items_sent, cal_sets);
    $display("%0d results compared, %0d of them saturated", checked, clipped_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== baro_sensor_compensation_unit.f =====
rtl/bscu_pkg.sv
rtl/bscu_cfg.sv
rtl/bscu_front.sv
rtl/bscu_horner.sv
rtl/baro_sensor_compensation_unit.sv
tb/baro_sensor_compensation_checker.sv
tb/tb_baro_sensor_compensation_unit.sv
